// File: rtl/smv_pkg.sv
// Shared constants, types and the 2^-x table of the softmax block.
package smv_pkg;

  localparam int MAX_LEN   = 16;
  localparam int ADDR_W    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CNT_W     = $clog2(MAX_LEN + 1);
  localparam int SCORE_W   = 16;
  localparam int EXP_W     = 16;
  localparam int PROB_W    = 16;
  localparam int IDX_W     = 4;
  localparam int SUM_W     = $clog2(MAX_LEN * 65535 + 1);
  localparam int QUO_W     = 17;
  localparam int NUM_W     = 33;
  localparam int LOG2E_Q16 = 94548;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_EXP,
    ST_DRD,
    ST_DSTART,
    ST_DWAIT,
    ST_OUT
  } state_t;

  // 2^(-i/16) in Q1.16
  function automatic logic [16:0] pow2_neg(input logic [4:0] i);
    logic [16:0] r;
    case (i)
      5'd0:    r = 17'd65536;
      5'd1:    r = 17'd62757;
      5'd2:    r = 17'd60097;
      5'd3:    r = 17'd57549;
      5'd4:    r = 17'd55109;
      5'd5:    r = 17'd52773;
      5'd6:    r = 17'd50536;
      5'd7:    r = 17'd48394;
      5'd8:    r = 17'd46341;
      5'd9:    r = 17'd44376;
      5'd10:   r = 17'd42495;
      5'd11:   r = 17'd40693;
      5'd12:   r = 17'd38968;
      5'd13:   r = 17'd37316;
      5'd14:   r = 17'd35734;
      5'd15:   r = 17'd34219;
      default: r = 17'd32768;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/smv_if.sv
// Score and probability channel interfaces.
interface smv_in_if import smv_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [SCORE_W-1:0] score;
  logic                      last_in;
  modport source (output valid, score, last_in, input ready);
  modport sink (input valid, score, last_in, output ready);
endinterface

interface smv_out_if import smv_pkg::*;;
  logic              valid;
  logic              ready;
  logic [PROB_W-1:0] prob;
  logic [IDX_W-1:0]  elem_index;
  logic              last_out;
  logic              overflow;
  modport source (output valid, prob, elem_index, last_out, overflow, input ready);
  modport sink (input valid, prob, elem_index, last_out, overflow, output ready);
endinterface

// File: rtl/smv_exp.sv
// Three-stage pipelined exp(-d) unit, Q8.8 in, Q0.16 out.
module smv_exp import smv_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [15:0]       d,
  input  logic [ADDR_W-1:0] in_tag,
  output logic              out_valid,
  output logic [EXP_W-1:0]  e,
  output logic [ADDR_W-1:0] out_tag
);

  logic              v1, v2;
  logic [NUM_W-1:0]  y1;
  logic [ADDR_W-1:0] tag1, tag2;
  logic [16:0]       hi2;
  logic [24:0]       prod2;
  logic [8:0]        k2;

  logic [3:0]  idx;
  logic [7:0]  lo;
  logic [16:0] hi, step;
  logic [24:0] rnd;
  logic [16:0] interp;
  logic [17:0] shifted;
  logic [4:0]  ks;

  always_comb begin
    idx  = y1[23:20];
    lo   = y1[19:12];
    hi   = pow2_neg({1'b0, idx});
    step = hi - pow2_neg(5'({1'b0, idx}) + 5'd1);
  end

  always_comb begin
    rnd     = prod2 + 25'd128;
    interp  = hi2 - 17'(rnd >> 8);
    ks      = k2[4:0];
    shifted = 18'(interp);
    if (k2 >= 9'd17) begin
      shifted = '0;
    end else if (ks != 5'd0) begin
      shifted = (18'(interp) + (18'd1 << (ks - 5'd1))) >> ks;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
    y1      <= NUM_W'(d) * NUM_W'(LOG2E_Q16);
    tag1    <= in_tag;
    hi2     <= hi;
    prod2   <= 25'(step) * 25'(lo);
    k2      <= y1[32:24];
    tag2    <= tag1;
    e       <= (shifted > 18'd65535) ? 16'hFFFF : shifted[15:0];
    out_tag <= tag2;
  end

endmodule

// File: rtl/smv_div.sv
// Restoring divider, one quotient bit per cycle.
module smv_div import smv_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [SUM_W-1:0] den,
  output logic             done,
  output logic [QUO_W-1:0] quo
);

  logic             busy;
  logic [4:0]       cnt;
  logic [SUM_W:0]   rem;
  logic [SUM_W:0]   rem_sh;
  logic             take;

  always_comb begin
    rem_sh = {rem[SUM_W-1:0], quo[QUO_W-1]};
    take   = (rem_sh >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'(QUO_W);
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
    if (start) begin
      rem <= (SUM_W + 1)'(num[NUM_W-1:QUO_W]);
      quo <= num[QUO_W-1:0];
    end else if (busy) begin
      rem <= take ? (rem_sh - {1'b0, den}) : rem_sh;
      quo <= {quo[QUO_W-2:0], take};
    end
  end

endmodule

// File: rtl/softmax_vector_top.sv
// Softmax over one vector of Q8.8 scores, emitting Q0.16 probabilities.
//
//  channel | dir | payload                                 | beat
//  scores  | in  | score[15:0] signed, last_in             | one element
//  probs   | out | prob[15:0], elem_index[3:0], last_out,  | one probability
//          |     | overflow                                |
//
// Loading takes one element per cycle. After the last element the exp pass
// streams the score memory through the 3-stage exp pipeline. Each
// probability then takes a memory read, a divider start, 17 steps of the
// shared bit-serial divider and its done pulse, and then waits in the output
// register, which holds it while the output is stalled.
// Synchronous reset clears control state; memory contents stay undefined.
// Scores are not taken while the vector's results are being produced.
module softmax_vector_top import smv_pkg::*; (
  input logic         clk,
  input logic         rst,
  smv_in_if.sink      scores,
  smv_out_if.source   probs
);

  // state memories
  logic signed [SCORE_W-1:0] score_mem [MAX_LEN];
  logic [EXP_W-1:0]          exp_mem [MAX_LEN];
  logic signed [SCORE_W-1:0] score_q;
  logic [EXP_W-1:0]          exp_q;

  state_t state, state_next;

  logic signed [SCORE_W-1:0] running_max;
  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          iss;
  logic [CNT_W-1:0]          ret;
  logic [CNT_W-1:0]          pos;
  logic [SUM_W-1:0]          exp_sum;
  logic                      overflow_seen;
  logic                      rd_v;
  logic [ADDR_W-1:0]         rd_tag;

  logic              in_acc, out_acc;
  logic              x_valid;
  logic [EXP_W-1:0]  x_e;
  logic [ADDR_W-1:0] x_tag;
  logic [15:0]       diff;
  logic              div_start, div_done;
  logic [QUO_W-1:0]  quo;
  logic [NUM_W-1:0]  div_num;

  assign in_acc  = scores.valid && scores.ready;
  assign out_acc = probs.valid && probs.ready;
  assign scores.ready = (state == ST_LOAD);
  assign probs.valid  = (state == ST_OUT);

  // max minus score always lies in 0..65535
  assign diff      = 16'(17'(running_max) - 17'(score_q));
  assign div_start = (state == ST_DSTART);
  assign div_num   = NUM_W'({exp_q, 16'h0000}) + NUM_W'(exp_sum >> 1);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD:   if (in_acc && scores.last_in) state_next = ST_EXP;
      ST_EXP:    if (ret == count) state_next = ST_DRD;
      ST_DRD:    state_next = ST_DSTART;
      ST_DSTART: state_next = ST_DWAIT;
      ST_DWAIT:  if (div_done) state_next = ST_OUT;
      ST_OUT: begin
        if (out_acc) begin
          state_next = (pos + CNT_W'(1) == count) ? ST_LOAD : ST_DRD;
        end
      end
      default:   state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      running_max   <= 16'sh8000;
      count         <= '0;
      overflow_seen <= 1'b0;
      exp_sum       <= '0;
      iss           <= '0;
      ret           <= '0;
      pos           <= '0;
      rd_v          <= 1'b0;
    end else begin
      rd_v <= 1'b0;
      unique case (state)
        ST_LOAD: begin
          if (in_acc) begin
            if (count < CNT_W'(MAX_LEN)) begin
              count <= count + CNT_W'(1);
              if (scores.score > running_max) running_max <= scores.score;
            end else begin
              overflow_seen <= 1'b1;
            end
          end
          iss     <= '0;
          ret     <= '0;
          pos     <= '0;
          exp_sum <= '0;
        end
        ST_EXP: begin
          if (iss < count) begin
            rd_v <= 1'b1;
            iss  <= iss + CNT_W'(1);
          end
          if (x_valid) begin
            ret     <= ret + CNT_W'(1);
            exp_sum <= exp_sum + SUM_W'(x_e);
          end
        end
        ST_OUT: begin
          if (out_acc) begin
            if (pos + CNT_W'(1) == count) begin
              // drop the vector state for the next one
              running_max   <= 16'sh8000;
              count         <= '0;
              overflow_seen <= 1'b0;
              exp_sum       <= '0;
            end else begin
              pos <= pos + CNT_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // score memory: written on load, read during the exp pass
  always_ff @(posedge clk) begin
    if (in_acc && count < CNT_W'(MAX_LEN)) begin
      score_mem[count[ADDR_W-1:0]] <= scores.score;
    end
    score_q <= score_mem[iss[ADDR_W-1:0]];
    rd_tag  <= iss[ADDR_W-1:0];
  end

  // exp memory: written by the exp pipeline, read per probability
  always_ff @(posedge clk) begin
    if (x_valid) begin
      exp_mem[x_tag] <= x_e;
    end
    exp_q <= exp_mem[pos[ADDR_W-1:0]];
  end

  smv_exp u_exp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rd_v),
    .d         (diff),
    .in_tag    (rd_tag),
    .out_valid (x_valid),
    .e         (x_e),
    .out_tag   (x_tag)
  );

  smv_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (exp_sum),
    .done  (div_done),
    .quo   (quo)
  );

  // output register: load on divider completion, hold while stalled
  always_ff @(posedge clk) begin
    if (div_done) begin
      if (exp_sum == '0) begin
        probs.prob <= '0;
      end else begin
        probs.prob <= (quo > QUO_W'(65535)) ? 16'hFFFF : quo[PROB_W-1:0];
      end
      probs.elem_index <= IDX_W'(pos);
      probs.last_out   <= (pos + CNT_W'(1) == count);
      probs.overflow   <= overflow_seen;
    end
  end

endmodule

// File: rtl/smv_checker.sv
// Port-level checks on the softmax block, bound to the top level.
module smv_checker import smv_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [PROB_W-1:0] prob,
  input logic              last_out
);

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while a result is shown");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(prob))
    else $error("stalled result changed");

  a_end_reopens: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_out |=> in_ready)
    else $error("input not reopened after final result");

  a_next_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_out |=> !out_valid && !in_ready)
    else $error("result followed without divide");

endmodule

bind softmax_vector_top smv_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (scores.ready),
  .out_valid (probs.valid),
  .out_ready (probs.ready),
  .prob      (probs.prob),
  .last_out  (probs.last_out)
);

// File: tb/tb_if.sv
// Beat structures shared by the testbench driver and monitor.
package tb_softmax_types;
  typedef struct packed {
    logic [15:0] score;
    logic        last_in;
  } score_beat_t;

  typedef struct packed {
    logic [15:0] prob;
    logic [3:0]  elem_index;
    logic        last_out;
    logic        overflow;
  } prob_beat_t;
endpackage

// File: tb/tb.sv
// Self-checking testbench of the softmax vector block.
module tb;
  import smv_pkg::*;
  import tb_softmax_types::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  smv_in_if  scores ();
  smv_out_if probs ();

  softmax_vector_top dut (
    .clk    (clk),
    .rst    (rst),
    .scores (scores.sink),
    .probs  (probs.source)
  );

  // Predictor state: a private copy of the block's vector buffer.
  logic signed [15:0] vec_buf [MAX_LEN];
  logic signed [15:0] vec_max;
  int                 vec_cnt;
  bit                 vec_ovf;

  score_beat_t pending_scores [$];
  prob_beat_t  expected_probs [$];

  int  errors;
  int  phase;          // 0 none, 1 sender gaps, 2 receiver stalls, 3 both
  int  idle_cycles;

  // 2^(-i/16) in Q1.16
  function automatic int unsigned pow2_frac(int unsigned i);
    int unsigned t [17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50536, 48394,
                            46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219,
                            32768};
    return t[i];
  endfunction

  function automatic int unsigned exp_neg(int unsigned d);
    longint unsigned y;
    int unsigned k, f, hi, step, v;
    y = (longint'(d) * 94548) >> 12;
    k = int'(y >> 12);
    f = int'(y & 12'hFFF);
    hi = pow2_frac(f >> 8);
    step = hi - pow2_frac((f >> 8) + 1);
    v = hi - ((step * (f & 8'hFF) + 128) >> 8);
    if (k >= 17) return 0;
    if (k > 0) v = (v + (1 << (k - 1))) >> k;
    if (v > 65535) v = 65535;
    return v;
  endfunction

  // Fold one accepted score into the vector; on last, queue its probabilities.
  task automatic predict_probs(score_beat_t b);
    int unsigned e [MAX_LEN];
    int unsigned total;
    longint unsigned p;
    prob_beat_t r;
    if (vec_cnt < MAX_LEN) begin
      vec_buf[vec_cnt] = b.score;
      if ($signed(b.score) > vec_max) vec_max = b.score;
      vec_cnt++;
    end else begin
      vec_ovf = 1'b1;
    end
    if (!b.last_in) return;
    total = 0;
    for (int i = 0; i < vec_cnt; i++) begin
      e[i] = exp_neg(int'(vec_max) - int'(vec_buf[i]));
      total += e[i];
    end
    for (int i = 0; i < vec_cnt; i++) begin
      p = 0;
      if (total != 0) begin
        p = ((longint'(e[i]) << 16) + (total >> 1)) / total;
        if (p > 65535) p = 65535;
      end
      r.prob       = p[15:0];
      r.elem_index = i[3:0];
      r.last_out   = (i + 1 == vec_cnt);
      r.overflow   = vec_ovf;
      expected_probs.push_back(r);
    end
    vec_max = -16'sd32768;
    vec_cnt = 0;
    vec_ovf = 1'b0;
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  function automatic bit roll(int pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  // Driver: hold a beat until it is taken, then advance the queue.
  always @(posedge clk) begin
    if (rst) begin
      scores.valid   <= 1'b0;
      scores.score   <= '0;
      scores.last_in <= 1'b0;
    end else begin
      if (!scores.valid || scores.ready) begin
        if (scores.valid && scores.ready) predict_probs({scores.score, scores.last_in});
        if (pending_scores.size() > 0 &&
            !(((phase == 1) && roll(46)) || ((phase == 3) && roll(12)))) begin
          score_beat_t b;
          b = pending_scores.pop_front();
          scores.valid   <= 1'b1;
          scores.score   <= b.score;
          scores.last_in <= b.last_in;
        end else begin
          scores.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each taken probability against the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      probs.ready <= 1'b0;
    end else begin
      if (probs.valid && probs.ready) begin
        if (expected_probs.size() == 0) begin
          report_mismatch("unexpected beat, index", probs.elem_index, -1);
        end else begin
          prob_beat_t w;
          w = expected_probs.pop_front();
          if (probs.prob !== w.prob) report_mismatch("prob", probs.prob, w.prob);
          if (probs.elem_index !== w.elem_index)
            report_mismatch("elem_index", probs.elem_index, w.elem_index);
          if (probs.last_out !== w.last_out)
            report_mismatch("last_out", probs.last_out, w.last_out);
          if (probs.overflow !== w.overflow)
            report_mismatch("overflow", probs.overflow, w.overflow);
        end
      end
      probs.ready <= !(((phase == 2) && roll(46)) || ((phase == 3) && roll(12)));
    end
  end

  // Watchdog: count cycles with no beat on either side.
  always @(posedge clk) begin
    if (rst || (scores.valid && scores.ready) || (probs.valid && probs.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic push_score(logic [15:0] s, bit l);
    score_beat_t b;
    b.score = s;
    b.last_in = l;
    pending_scores.push_back(b);
  endtask

  // One well-formed vector of n elements with random or clustered content.
  task automatic push_vector(int n);
    logic [15:0] base;
    base = 16'($urandom);
    for (int i = 0; i < n; i++) begin
      if (roll(50)) push_score(16'($urandom), i == n - 1);
      else push_score(16'(base + $urandom_range(2047, 0) - 16'd1024), i == n - 1);
    end
  endtask

  task automatic wait_drained();
    while (pending_scores.size() > 0 || scores.valid || expected_probs.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    errors = 0;
    phase = 0;
    vec_max = -16'sd32768;
    vec_cnt = 0;
    vec_ovf = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: single element, extremes, equal scores, full buffer, overflow.
    push_score(16'h0000, 1'b1);
    push_score(16'h8000, 1'b0);
    push_score(16'h7FFF, 1'b1);
    push_score(16'h7FFF, 1'b0);
    push_score(16'h7FFF, 1'b0);
    push_score(16'hFFFF, 1'b1);
    for (int i = 0; i < 16; i++) push_score(16'(i * 256), 1'b0);
    push_score(16'h5555, 1'b0);
    push_score(16'hAAAA, 1'b1);   // last element dropped on a full buffer
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      phase = ph;
      for (int v = 0; v < 8; v++) begin
        if (roll(8)) push_vector($urandom_range(24, 17));
        else if (roll(15)) push_vector(16);
        else push_vector($urandom_range(8, 1));
      end
      wait_drained();
    end
    phase = 0;
    repeat (400) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
